/* src/stbh_pkg.sv */
`timescale 1ns / 1ps
`default_nettype none

package stbh_pkg;

  localparam int TREE_HEIGHT_DEF = 8;
  localparam int COUNT_WIDTH_DEF = 32;

  localparam int MAG_W = 31;
  localparam logic [MAG_W-1:0] INF_MAG = 31'h7F800000;

  typedef enum logic [1:0] {
    MODE_LOAD     = 2'd0,
    MODE_CLASSIFY = 2'd1,
    MODE_RANK     = 2'd2,
    MODE_CLEAR    = 2'd3
  } mode_t;

  typedef enum logic [2:0] {
    ST_INIT,
    ST_IDLE,
    ST_CLS,
    ST_INC,
    ST_RANK,
    ST_THR,
    ST_CLR,
    ST_OUT
  } state_t;

  typedef struct packed {
    mode_t       mode;
    logic [7:0]  slot;
    logic [31:0] value_bits;
    logic [31:0] rank;
  } item_t;

  typedef struct packed {
    logic [7:0]       bucket;
    logic [31:0]      base_rank;
    logic [31:0]      bucket_size;
    logic [MAG_W-1:0] threshold_bits;
    logic             rank_ok;
  } result_t;

endpackage

`default_nettype wire

/* src/stbh_ram.sv */
`timescale 1ns / 1ps
`default_nettype none

module stbh_ram #(
  parameter int ADDR_W = 8,
  parameter int DATA_W = 32
) (
  input  wire logic              clk,
  input  wire logic              we,
  input  wire logic [ADDR_W-1:0] waddr,
  input  wire logic [DATA_W-1:0] wdata,
  input  wire logic [ADDR_W-1:0] raddr,
  output logic      [DATA_W-1:0] rdata
);

  logic [DATA_W-1:0] mem [(1 << ADDR_W)];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    rdata <= mem[raddr];
  end

endmodule

`default_nettype wire

/* src/splitter_tree_bucket_histogram.sv */
`timescale 1ns / 1ps
`default_nettype none

// channel   direction  handshake                      payload
// item      in         item_valid / item_ready        stbh_pkg::item_t
// result    out        result_valid / result_ready    stbh_pkg::result_t
//
// load goes straight to the output state; classify does one splitter compare a
// cycle on the splitter ram read port, then a count read-modify-write; rank query
// reads one count a cycle from the count ram; clear writes zero to every count.
// after reset a clearing pass over the count ram runs with item_ready low.
// item_ready is high only when the sequencer is idle; a finished result waits
// in the output register while the next item is taken.

module splitter_tree_bucket_histogram #(
  parameter int TREE_HEIGHT = stbh_pkg::TREE_HEIGHT_DEF,
  parameter int COUNT_WIDTH = stbh_pkg::COUNT_WIDTH_DEF
) (
  input  wire logic               clk,
  input  wire logic               rst,
  input  wire logic               item_valid,
  output logic                    item_ready,
  input  wire stbh_pkg::item_t    item,
  output logic                    result_valid,
  input  wire logic               result_ready,
  output stbh_pkg::result_t       result
);

  localparam int TH = TREE_HEIGHT;
  localparam int CW = COUNT_WIDTH;
  localparam int MW = stbh_pkg::MAG_W;
  localparam int NUM_BUCKETS = 1 << TH;
  localparam int BW = (TH > 8) ? TH : 8;
  localparam int SW = ((CW > 32) ? CW : 32) + 1;
  localparam logic [TH-1:0] ROOT = TH'(1) << (TH - 1);

  stbh_pkg::state_t state, state_next;

  logic [MW-1:0] key_q;
  logic [31:0]   rank_q;
  logic [TH-1:0] probe;
  logic [TH-1:0] idx;
  logic [TH-1:0] bucket_r;
  logic [31:0]   base_r;
  logic [31:0]   size_r;
  logic [MW-1:0] thr_r;
  logic          ok_r;

  logic          sp_we;
  logic [TH-1:0] sp_waddr;
  logic [MW-1:0] sp_wdata;
  logic [TH-1:0] sp_raddr;
  logic [MW-1:0] sp_rdata;
  logic          cn_we;
  logic [TH-1:0] cn_waddr;
  logic [CW-1:0] cn_wdata;
  logic [TH-1:0] cn_raddr;
  logic [CW-1:0] cn_rdata;

  logic          take;
  logic [BW-1:0] slot_w;
  logic          slot_ok;
  logic [TH-1:0] cand;
  logic          not_less;
  logic [TH-1:0] nb;
  logic [SW-1:0] next_sum;
  logic [SW-1:0] cnt_w;
  logic [31:0]   cnt_sat;
  logic          hit;
  logic          last;
  logic          out_free;
  logic [BW-1:0] bucket_w;

  assign item_ready = (state == stbh_pkg::ST_IDLE);
  assign take       = item_valid && item_ready;
  assign out_free   = !result_valid || result_ready;

  assign slot_w  = BW'(item.slot);
  assign slot_ok = (item.slot != 8'd0) && (32'(item.slot) < NUM_BUCKETS);

  // one tree level per cycle
  assign cand     = bucket_r | probe;
  assign not_less = (key_q > stbh_pkg::INF_MAG) || (sp_rdata > stbh_pkg::INF_MAG) ||
                    (key_q >= sp_rdata);
  assign nb       = not_less ? cand : bucket_r;

  // cumulative walk
  assign next_sum = SW'(base_r) + SW'(cn_rdata);
  assign hit      = next_sum > SW'(rank_q);
  assign last     = (idx == {TH{1'b1}});
  assign cnt_w    = SW'(cn_rdata);
  assign cnt_sat  = (cnt_w > SW'(32'hFFFFFFFF)) ? 32'hFFFFFFFF : cnt_w[31:0];

  stbh_ram #(
    .ADDR_W (TH),
    .DATA_W (MW)
  ) u_splitters (
    .clk   (clk),
    .we    (sp_we),
    .waddr (sp_waddr),
    .wdata (sp_wdata),
    .raddr (sp_raddr),
    .rdata (sp_rdata)
  );

  stbh_ram #(
    .ADDR_W (TH),
    .DATA_W (CW)
  ) u_counts (
    .clk   (clk),
    .we    (cn_we),
    .waddr (cn_waddr),
    .wdata (cn_wdata),
    .raddr (cn_raddr),
    .rdata (cn_rdata)
  );

  always_comb begin
    state_next = state;
    unique case (state)
      stbh_pkg::ST_INIT: begin
        if (last) state_next = stbh_pkg::ST_IDLE;
      end
      stbh_pkg::ST_IDLE: begin
        if (item_valid) begin
          unique case (item.mode)
            stbh_pkg::MODE_LOAD:     state_next = stbh_pkg::ST_OUT;
            stbh_pkg::MODE_CLASSIFY: state_next = stbh_pkg::ST_CLS;
            stbh_pkg::MODE_RANK:     state_next = stbh_pkg::ST_RANK;
            stbh_pkg::MODE_CLEAR:    state_next = stbh_pkg::ST_CLR;
            default:                 state_next = stbh_pkg::ST_OUT;
          endcase
        end
      end
      stbh_pkg::ST_CLS: begin
        if (probe[0]) state_next = stbh_pkg::ST_INC;
      end
      stbh_pkg::ST_INC: state_next = stbh_pkg::ST_OUT;
      stbh_pkg::ST_RANK: begin
        if (hit || last) state_next = stbh_pkg::ST_THR;
      end
      stbh_pkg::ST_THR: state_next = stbh_pkg::ST_OUT;
      stbh_pkg::ST_CLR: begin
        if (last) state_next = stbh_pkg::ST_OUT;
      end
      stbh_pkg::ST_OUT: begin
        if (out_free) state_next = stbh_pkg::ST_IDLE;
      end
      default: state_next = stbh_pkg::ST_INIT;
    endcase
  end

  always_comb begin
    sp_we    = 1'b0;
    sp_waddr = slot_w[TH-1:0];
    sp_wdata = item.value_bits[MW-1:0];
    sp_raddr = ROOT;
    cn_we    = 1'b0;
    cn_waddr = idx;
    cn_wdata = '0;
    cn_raddr = '0;
    unique case (state)
      stbh_pkg::ST_IDLE: begin
        sp_we = take && (item.mode == stbh_pkg::MODE_LOAD) && slot_ok;
      end
      stbh_pkg::ST_INIT, stbh_pkg::ST_CLR: begin
        cn_we = 1'b1;
      end
      stbh_pkg::ST_CLS: begin
        sp_raddr = nb | (probe >> 1);
        cn_raddr = nb;
      end
      stbh_pkg::ST_INC: begin
        cn_we    = 1'b1;
        cn_waddr = bucket_r;
        cn_wdata = (cn_rdata == {CW{1'b1}}) ? cn_rdata : cn_rdata + CW'(1);
      end
      stbh_pkg::ST_RANK: begin
        sp_raddr = idx;
        cn_raddr = idx + TH'(1);
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= stbh_pkg::ST_INIT;
      idx   <= '0;
    end else begin
      state <= state_next;
      unique case (state)
        stbh_pkg::ST_INIT, stbh_pkg::ST_CLR: idx <= idx + TH'(1);
        stbh_pkg::ST_IDLE: begin
          if (take) idx <= '0;
        end
        stbh_pkg::ST_RANK: begin
          if (!(hit || last)) idx <= idx + TH'(1);
        end
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    unique case (state)
      stbh_pkg::ST_IDLE: begin
        if (take) begin
          key_q    <= item.value_bits[MW-1:0];
          rank_q   <= item.rank;
          probe    <= ROOT;
          bucket_r <= '0;
          base_r   <= '0;
          size_r   <= '0;
          thr_r    <= '0;
          ok_r     <= 1'b0;
        end
      end
      stbh_pkg::ST_CLS: begin
        bucket_r <= nb;
        probe    <= probe >> 1;
      end
      stbh_pkg::ST_RANK: begin
        if (hit || last) begin
          bucket_r <= idx;
          size_r   <= cnt_sat;
          ok_r     <= hit;
        end else begin
          base_r <= next_sum[31:0];
        end
      end
      stbh_pkg::ST_THR: begin
        thr_r <= (bucket_r == '0) ? '0 : sp_rdata;
      end
      default: begin
      end
    endcase
  end

  assign bucket_w = BW'(bucket_r);

  always_ff @(posedge clk) begin
    if (rst) begin
      result_valid <= 1'b0;
    end else if (state == stbh_pkg::ST_OUT && out_free) begin
      result_valid <= 1'b1;
    end else if (result_ready) begin
      result_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (state == stbh_pkg::ST_OUT && out_free) begin
      result.bucket         <= bucket_w[7:0];
      result.base_rank      <= base_r;
      result.bucket_size    <= size_r;
      result.threshold_bits <= thr_r;
      result.rank_ok        <= ok_r;
    end
  end

endmodule

`default_nettype wire
